// ----- hw/rtl/gcd_pkg.sv -----
// Shared types, constants and the arctangent table for the great-circle distance unit.
// Used by the CORDIC cell, the square-root cell and the top level; depends on nothing.
package gcd_pkg;

    // CORDIC x/y datapath and angle accumulator, Q2.30 with headroom.
    typedef logic signed [33:0] t_cxy;
    typedef logic signed [32:0] t_cz;
    // Square-root remainder and partial root.
    typedef logic [61:0] t_rem;
    typedef logic [30:0] t_root;

    localparam logic signed [32:0] LAT_LIMIT    = 33'sd900000000;
    localparam logic signed [32:0] LON_LIMIT    = 33'sd1800000000;
    localparam logic signed [32:0] HALF_TURN    = 33'sd1800000000;
    localparam logic signed [32:0] QUARTER_TURN = 33'sd900000000;
    localparam logic signed [32:0] FULL_TURN    = 33'sd3600000000;
    localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
    localparam logic [31:0] DEG_TO_RAD =
        32'(64'h3243F6A8885A308D / 64'd1800000000);
    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sh026DD3B6A;
    localparam logic [33:0] DIAMETER_MM = 34'd12742017600;
    localparam logic [34:0] DIST_MAX    = 35'd20015087000;
    localparam int SQRT_BITS = 31;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/gcd_cordic_cell.sv -----
// One registered CORDIC micro-rotation, in rotation or vectoring mode.
// Depends on gcd_pkg for the datapath types and the arctangent table.
module gcd_cordic_cell #(
    parameter int STAGE     = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic            i_clk,
    input  gcd_pkg::t_cxy   i_x,
    input  gcd_pkg::t_cxy   i_y,
    input  gcd_pkg::t_cz    i_z,
    output gcd_pkg::t_cxy   o_x,
    output gcd_pkg::t_cxy   o_y,
    output gcd_pkg::t_cz    o_z
);

    localparam gcd_pkg::t_cz ATAN =
        gcd_pkg::t_cz'(gcd_pkg::atan_q30(5'(STAGE)));

    gcd_pkg::t_cxy w_xs;
    gcd_pkg::t_cxy w_ys;
    logic          w_pos;

    assign w_xs = i_x >>> STAGE;
    assign w_ys = i_y >>> STAGE;
    // Rotation drives z toward zero; vectoring drives y toward zero.
    assign w_pos = VECTORING ? (i_y <= 0) : (i_z >= 0);

    always_ff @(posedge i_clk) begin
        if (w_pos) begin
            o_x <= i_x - w_ys;
            o_y <= i_y + w_xs;
            o_z <= i_z - ATAN;
        end else begin
            o_x <= i_x + w_ys;
            o_y <= i_y - w_xs;
            o_z <= i_z + ATAN;
        end
    end

endmodule

// ----- hw/rtl/gcd_sqrt_cell.sv -----
// One registered step of a digit-by-digit integer square root: settles one root bit.
// Depends on gcd_pkg for the remainder and root types.
module gcd_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic            i_clk,
    input  gcd_pkg::t_rem   i_rem,
    input  gcd_pkg::t_root  i_root,
    output gcd_pkg::t_rem   o_rem,
    output gcd_pkg::t_root  o_root
);

    gcd_pkg::t_rem w_trial;

    // (root + 2^BIT)^2 - root^2 = root * 2^(BIT+1) + 2^(2*BIT)
    assign w_trial = (gcd_pkg::t_rem'(i_root) << (BIT + 1))
                   + (gcd_pkg::t_rem'(1) << (2 * BIT));

    always_ff @(posedge i_clk) begin
        if (i_rem >= w_trial) begin
            o_rem  <= i_rem - w_trial;
            o_root <= i_root | (gcd_pkg::t_root'(1) << BIT);
        end else begin
            o_rem  <= i_rem;
            o_root <= i_root;
        end
    end

endmodule

// ----- hw/rtl/great_circle_distance_unit.sv -----
// Top level of the great-circle (haversine) distance unit.
// Depends on gcd_pkg, gcd_cordic_cell and gcd_sqrt_cell.
//
// Usage: drive the four coordinates (degrees times 1e7) and pulse i_start.
// o_busy is always low, so a transfer happens at every edge where i_start
// is high and a new point pair may enter in every cycle. Each pair yields
// one distance in millimetres on o_distance_mm, marked by o_done for one
// cycle. Throughput is one pair per cycle; the pipeline depth comes mostly
// from the rotation and vectoring CORDIC rows and the two 31-cell
// square-root rows. Results leave in the order the pairs came in. The
// receiver cannot stall, so no result is ever held back. Synchronous reset
// clears all valid flags, so no result appears for cycles before the first
// transfer after reset; data in flight at reset is dropped.
module great_circle_distance_unit #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [30:0] i_lat_a,
    input  logic signed [31:0] i_lon_a,
    input  logic signed [30:0] i_lat_b,
    input  logic signed [31:0] i_lon_b,
    output logic               o_done,
    output logic [34:0]        o_distance_mm
);

    localparam int N   = CORDIC_STAGES;
    localparam int SB  = gcd_pkg::SQRT_BITS;
    localparam int LAT = 75 + 2 * N;

    // Valid flags, one per pipeline stage.
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;

    assign n_vld = {r_vld[LAT-2:0], i_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_busy = 1'b0;
    assign o_done = r_vld[LAT-1];

    // Stage 1: saturate the inputs. Order: lat_a, lon_a, lat_b, lon_b.
    logic signed [32:0] w_in [0:3];
    logic signed [32:0] r1_pt [0:3];

    assign w_in[0] = 33'(i_lat_a);
    assign w_in[1] = 33'(i_lon_a);
    assign w_in[2] = 33'(i_lat_b);
    assign w_in[3] = 33'(i_lon_b);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (k % 2 == 0) begin
                r1_pt[k] <= (w_in[k] > gcd_pkg::LAT_LIMIT) ? gcd_pkg::LAT_LIMIT :
                            (w_in[k] < -gcd_pkg::LAT_LIMIT) ? -gcd_pkg::LAT_LIMIT :
                            w_in[k];
            end else begin
                r1_pt[k] <= (w_in[k] > gcd_pkg::LON_LIMIT) ? gcd_pkg::LON_LIMIT :
                            (w_in[k] < -gcd_pkg::LON_LIMIT) ? -gcd_pkg::LON_LIMIT :
                            w_in[k];
            end
        end
    end

    // Stage 2: the four angles whose cosines are needed:
    // dlat, dlon (wrapped to a half turn), lat_a, lat_b.
    logic signed [32:0] w_dlon;
    logic signed [32:0] r2_ang [0:3];

    assign w_dlon = r1_pt[3] - r1_pt[1];

    always_ff @(posedge i_clk) begin
        r2_ang[0] <= r1_pt[2] - r1_pt[0];
        if (w_dlon > gcd_pkg::HALF_TURN) begin
            r2_ang[1] <= w_dlon - gcd_pkg::FULL_TURN;
        end else if (w_dlon < -gcd_pkg::HALF_TURN) begin
            r2_ang[1] <= w_dlon + gcd_pkg::FULL_TURN;
        end else begin
            r2_ang[1] <= w_dlon;
        end
        r2_ang[2] <= r1_pt[0];
        r2_ang[3] <= r1_pt[2];
    end

    // Stage 3: fold each angle into the first quadrant; past a quarter turn
    // the cosine changes sign.
    logic signed [32:0] w_mag [0:3];
    logic [29:0]        r3_v   [0:3];
    logic               r3_neg [0:3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_mag[k] = (r2_ang[k] < 0) ? -r2_ang[k] : r2_ang[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (w_mag[k] > gcd_pkg::QUARTER_TURN) begin
                r3_v[k]   <= 30'(gcd_pkg::HALF_TURN - w_mag[k]);
                r3_neg[k] <= 1'b1;
            end else begin
                r3_v[k]   <= 30'(w_mag[k]);
                r3_neg[k] <= 1'b0;
            end
        end
    end

    // Stage 4: degrees times 1e7 to radians in Q2.30.
    logic [61:0]       w_rad [0:3];
    gcd_pkg::t_cz      r4_z   [0:3];
    logic              r4_neg [0:3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_rad[k] = 62'(r3_v[k]) * 62'(gcd_pkg::DEG_TO_RAD);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r4_z[k]   <= gcd_pkg::t_cz'({2'b00, w_rad[k][60:30]});
            r4_neg[k] <= r3_neg[k];
        end
    end

    // Four rows of rotation cells, one per angle; the sign flags travel
    // alongside in a matching row of registers.
    gcd_pkg::t_cxy w_rx [0:3][0:N];
    gcd_pkg::t_cxy w_ry [0:3][0:N];
    gcd_pkg::t_cz  w_rz [0:3][0:N];
    logic          r_neg_line [0:3][0:N-1];

    for (genvar l = 0; l < 4; l++) begin : g_lane
        assign w_rx[l][0] = gcd_pkg::CORDIC_GAIN_INV;
        assign w_ry[l][0] = '0;
        assign w_rz[l][0] = r4_z[l];
        for (genvar j = 0; j < N; j++) begin : g_cell
            gcd_cordic_cell #(
                .STAGE     (j),
                .VECTORING (1'b0)
            ) u_cell (
                .i_clk (i_clk),
                .i_x   (w_rx[l][j]),
                .i_y   (w_ry[l][j]),
                .i_z   (w_rz[l][j]),
                .o_x   (w_rx[l][j+1]),
                .o_y   (w_ry[l][j+1]),
                .o_z   (w_rz[l][j+1])
            );
            always_ff @(posedge i_clk) begin
                r_neg_line[l][j] <= (j == 0) ? r4_neg[l] : r_neg_line[l][(j == 0) ? 0 : j-1];
            end
        end
    end

    // Stage 5: clamp, restore sign; latitude cosines are never negative.
    gcd_pkg::t_cxy      w_xc  [0:3];
    gcd_pkg::t_cxy      w_cs  [0:3];
    logic signed [31:0] r5_cos [0:3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_xc[k] = (w_rx[k][N] > gcd_pkg::ONE_Q30) ? gcd_pkg::ONE_Q30 :
                      (w_rx[k][N] < -gcd_pkg::ONE_Q30) ? -gcd_pkg::ONE_Q30 :
                      w_rx[k][N];
            w_cs[k] = r_neg_line[k][N-1] ? -w_xc[k] : w_xc[k];
            if (k >= 2 && w_cs[k] < 0) begin
                w_cs[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r5_cos[k] <= 32'(w_cs[k]);
        end
    end

    // Stage 6: haversine halves and the latitude cosine product.
    logic signed [33:0] w_h1;
    logic signed [33:0] w_h2;
    logic [61:0]        w_pp;
    logic [30:0]        r6_h1;
    logic [31:0]        r6_h2;
    logic [30:0]        r6_p;

    assign w_h1 = (gcd_pkg::ONE_Q30 - 34'(r5_cos[0])) >>> 1;
    assign w_h2 = gcd_pkg::ONE_Q30 - 34'(r5_cos[1]);
    assign w_pp = 62'(r5_cos[2][30:0]) * 62'(r5_cos[3][30:0]);

    always_ff @(posedge i_clk) begin
        r6_h1 <= 31'(w_h1);
        r6_h2 <= 32'(w_h2);
        r6_p  <= w_pp[60:30];
    end

    // Stage 7: product of the cosine term and (1 - cos dlon).
    logic [62:0] r7_ph;
    logic [30:0] r7_h1;

    always_ff @(posedge i_clk) begin
        r7_ph <= 63'(r6_p) * 63'(r6_h2);
        r7_h1 <= r6_h1;
    end

    // Stage 8: a, held to at most one.
    logic [31:0] w_a;
    logic [30:0] r8_a;

    assign w_a = 32'(r7_h1) + 32'(r7_ph[62:31]);

    always_ff @(posedge i_clk) begin
        r8_a <= (w_a > 32'(gcd_pkg::ONE_Q30)) ? 31'(gcd_pkg::ONE_Q30) : 31'(w_a);
    end

    // First square-root row: s = sqrt(a * 2^30).
    gcd_pkg::t_rem  w_rem1  [0:SB];
    gcd_pkg::t_root w_root1 [0:SB];

    assign w_rem1[0]  = gcd_pkg::t_rem'(r8_a) << 30;
    assign w_root1[0] = '0;

    for (genvar j = 0; j < SB; j++) begin : g_sqrt1
        gcd_sqrt_cell #(
            .BIT (SB - 1 - j)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rem  (w_rem1[j]),
            .i_root (w_root1[j]),
            .o_rem  (w_rem1[j+1]),
            .o_root (w_root1[j+1])
        );
    end

    // s squared, then the radicand of c = sqrt(1 - s^2).
    logic [61:0]    r_ss;
    gcd_pkg::t_root r_s1;
    gcd_pkg::t_rem  r_rem0;
    gcd_pkg::t_root r_s2;

    always_ff @(posedge i_clk) begin
        r_ss   <= 62'(w_root1[SB]) * 62'(w_root1[SB]);
        r_s1   <= w_root1[SB];
        r_rem0 <= (gcd_pkg::t_rem'(1) << 60) - r_ss;
        r_s2   <= r_s1;
    end

    // Second square-root row, with s carried alongside.
    gcd_pkg::t_rem  w_rem2  [0:SB];
    gcd_pkg::t_root w_root2 [0:SB];
    gcd_pkg::t_root r_s_line [0:SB-1];

    assign w_rem2[0]  = r_rem0;
    assign w_root2[0] = '0;

    for (genvar j = 0; j < SB; j++) begin : g_sqrt2
        gcd_sqrt_cell #(
            .BIT (SB - 1 - j)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rem  (w_rem2[j]),
            .i_root (w_root2[j]),
            .o_rem  (w_rem2[j+1]),
            .o_root (w_root2[j+1])
        );
        always_ff @(posedge i_clk) begin
            r_s_line[j] <= (j == 0) ? r_s2 : r_s_line[(j == 0) ? 0 : j-1];
        end
    end

    // Vectoring row: t = atan2(s, c).
    gcd_pkg::t_cxy w_vx [0:N];
    gcd_pkg::t_cxy w_vy [0:N];
    gcd_pkg::t_cz  w_vz [0:N];

    assign w_vx[0] = gcd_pkg::t_cxy'(w_root2[SB]);
    assign w_vy[0] = gcd_pkg::t_cxy'(r_s_line[SB-1]);
    assign w_vz[0] = '0;

    for (genvar j = 0; j < N; j++) begin : g_vec
        gcd_cordic_cell #(
            .STAGE     (j),
            .VECTORING (1'b1)
        ) u_cell (
            .i_clk (i_clk),
            .i_x   (w_vx[j]),
            .i_y   (w_vy[j]),
            .i_z   (w_vz[j]),
            .o_x   (w_vx[j+1]),
            .o_y   (w_vy[j+1]),
            .o_z   (w_vz[j+1])
        );
    end

    // Scale the angle by the diameter in two partial products.
    logic [31:0] w_t;
    logic [50:0] r_q;
    logic [48:0] r_r;

    assign w_t = (w_vz[N] < 0) ? '0 : 32'(w_vz[N]);

    always_ff @(posedge i_clk) begin
        r_q <= 51'(gcd_pkg::DIAMETER_MM) * 51'(w_t[31:15]);
        r_r <= 49'(gcd_pkg::DIAMETER_MM) * 49'(w_t[14:0]);
    end

    logic [51:0] r_u;

    always_ff @(posedge i_clk) begin
        r_u <= 52'(r_q) + 52'(r_r[48:15]);
    end

    // Round to millimetres and hold to half the circumference.
    logic [52:0] w_rnd;
    logic [37:0] w_dist;

    assign w_rnd  = 53'(r_u) + 53'(1 << 14);
    assign w_dist = w_rnd[52:15];

    always_ff @(posedge i_clk) begin
        o_distance_mm <= (w_dist > 38'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX
                                                           : 35'(w_dist);
    end

endmodule

// ----- sim/gcd_distance_checker.sv -----
`timescale 1ns / 1ps
// Checker for the great-circle distance unit: predicts each distance from the accepted
// point pair and compares it with the distance that comes out. Depends on nothing.
module gcd_distance_checker #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic signed [30:0] i_lat_a,
    input  logic signed [31:0] i_lon_a,
    input  logic signed [30:0] i_lat_b,
    input  logic signed [31:0] i_lon_b,
    input  logic               i_done,
    input  logic [34:0]        i_distance_mm,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam longint LAT_SAT   = 64'sd900000000;
    localparam longint LON_SAT   = 64'sd1800000000;
    localparam longint HALF_DEG  = 64'sd1800000000;
    localparam longint QUART_DEG = 64'sd900000000;
    localparam longint FULL_DEG  = 64'sd3600000000;
    localparam longint UNITY     = 64'sd1 << 30;
    localparam longint unsigned RAD_SCALE = 64'h3243F6A8885A308D / 64'd1800000000;
    localparam longint unsigned EARTH_DIAM_MM = 64'd12742017600;
    localparam longint unsigned DIST_CEIL = 64'd20015087000;

    localparam longint ARCTAN [32] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
        'h00000001, 'h00000000
    };

    logic [34:0] distance_queue[$];
    int          mismatch_count;

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint rotate_cos(longint angle);
        longint x, y, z, xs, ys;
        x = 64'sh26DD3B6A;
        y = 0;
        z = angle;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ARCTAN[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ARCTAN[i];
            end
        end
        return sat(x, -UNITY, UNITY);
    endfunction

    function automatic longint cosine_of_degrees(longint v);
        logic            flip;
        longint unsigned rad;
        longint          c;
        flip = 1'b0;
        if (v < 0)
            v = -v;
        // Beyond a quarter turn the cosine is folded back and negated.
        if (v > QUART_DEG) begin
            v = HALF_DEG - v;
            flip = 1'b1;
        end
        rad = (longint'(unsigned'(v)) * RAD_SCALE) >> 30;
        c = rotate_cos(longint'(rad));
        return flip ? -c : c;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint vector_atan2(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ARCTAN[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ARCTAN[i];
            end
        end
        return z < 0 ? 0 : z;
    endfunction

    function automatic logic [34:0] haversine_mm(logic signed [30:0] lat_a_in,
                                                 logic signed [31:0] lon_a_in,
                                                 logic signed [30:0] lat_b_in,
                                                 logic signed [31:0] lon_b_in);
        longint lat_a, lon_a, lat_b, lon_b, dlat, dlon;
        longint c_dlat, c_dlon, c_a, c_b, h1, h2, p, a, s, c, t;
        longint unsigned q, r, u, dist_mm;
        lat_a = sat(longint'(lat_a_in), -LAT_SAT, LAT_SAT);
        lon_a = sat(longint'(lon_a_in), -LON_SAT, LON_SAT);
        lat_b = sat(longint'(lat_b_in), -LAT_SAT, LAT_SAT);
        lon_b = sat(longint'(lon_b_in), -LON_SAT, LON_SAT);
        dlat = lat_b - lat_a;
        dlon = lon_b - lon_a;
        if (dlon > HALF_DEG)
            dlon = dlon - FULL_DEG;
        else if (dlon < -HALF_DEG)
            dlon = dlon + FULL_DEG;
        c_dlat = cosine_of_degrees(dlat);
        c_dlon = cosine_of_degrees(dlon);
        c_a = sat(cosine_of_degrees(lat_a), 0, UNITY);
        c_b = sat(cosine_of_degrees(lat_b), 0, UNITY);
        h1 = (UNITY - c_dlat) >>> 1;
        h2 = UNITY - c_dlon;
        p = (c_a * c_b) >>> 30;
        a = sat(h1 + ((p * h2) >>> 31), 0, UNITY);
        s = longint'(int_sqrt(longint'(unsigned'(a)) << 30));
        c = longint'(int_sqrt((64'd1 << 60) - longint'(unsigned'(s * s))));
        t = vector_atan2(s, c);
        q = EARTH_DIAM_MM * (longint'(unsigned'(t)) >> 15);
        r = EARTH_DIAM_MM * (longint'(unsigned'(t)) & 64'h7FFF);
        u = q + (r >> 15);
        dist_mm = (u + (64'd1 << 14)) >> 15;
        if (dist_mm > DIST_CEIL)
            dist_mm = DIST_CEIL;
        return dist_mm[34:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            distance_queue.delete();
        end else begin
            if (i_done) begin
                if (distance_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: distance %0d with no transfer waiting",
                                 $realtime, i_distance_mm);
                end else begin
                    logic [34:0] want;
                    want = distance_queue.pop_front();
                    if (want !== i_distance_mm) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: distance_mm expected %0d got %0d",
                                     $realtime, want, i_distance_mm);
                    end
                end
            end
            if (i_start && !i_busy)
                distance_queue.push_back(haversine_mm(i_lat_a, i_lon_a, i_lat_b, i_lon_b));
        end
    end

    initial mismatch_count = 0;
    assign o_fail_count = mismatch_count;
    assign o_pending = distance_queue.size();

endmodule

// ----- sim/tb_great_circle_distance_unit.sv -----
`timescale 1ns / 1ps
// Testbench top for the great-circle distance unit: drives point pairs and gives the verdict.
// Depends on gcd_distance_checker and the unit's RTL.
module tb_great_circle_distance_unit;

    localparam int CYCLE_LIMIT = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic signed [30:0] i_lat_a = '0;
    logic signed [31:0] i_lon_a = '0;
    logic signed [30:0] i_lat_b = '0;
    logic signed [31:0] i_lon_b = '0;
    logic               o_busy;
    logic               o_done;
    logic [34:0]        o_distance_mm;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    int                 gap_percent = 0;

    always #5 i_clk = ~i_clk;

    great_circle_distance_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_lat_a(i_lat_a), .i_lon_a(i_lon_a), .i_lat_b(i_lat_b), .i_lon_b(i_lon_b),
        .o_done(o_done), .o_distance_mm(o_distance_mm)
    );

    gcd_distance_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_lat_a(i_lat_a), .i_lon_a(i_lon_a), .i_lat_b(i_lat_b), .i_lon_b(i_lon_b),
        .i_done(o_done), .i_distance_mm(o_distance_mm),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    // Each cycle is left idle with a chance of gap_percent in a hundred.
    task automatic send_pair(int la, int lo, int lb, int lob);
        while ($urandom_range(99) < gap_percent) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_lat_a <= la[30:0];
        i_lon_a <= lo;
        i_lat_b <= lb[30:0];
        i_lon_b <= lob;
        i_start <= 1'b1;
        #1;
        while (o_busy)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic int rand_lat();
        return $urandom_range(1800000000) - 900000000;
    endfunction

    function automatic int rand_lon();
        return int'(longint'($urandom_range(32'hFFFFFFFF) % 3600000001) - 1800000000);
    endfunction

    initial begin
        int la, lo, lb, lob;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed pairs: identical points, poles, antipodes, date-line wrap, saturation.
        send_pair(0, 0, 0, 0);
        send_pair(900000000, 0, -900000000, 0);
        send_pair(0, 0, 0, 1800000000);
        send_pair(0, -1800000000, 0, 1800000000);
        send_pair(0, 1799999999, 0, -1799999999);
        send_pair(0, -1700000000, 0, 1700000000);
        send_pair(451234567, 123456789, 451234567, 123456789);
        send_pair(32'h3FFFFFFF, 32'h7FFFFFFF, -32'h40000000, 32'h80000000);
        send_pair(-32'h40000000, 32'h80000000, 32'h3FFFFFFF, 32'h7FFFFFFF);
        send_pair(900000001, 1800000001, -900000001, -1800000001);
        send_pair(900000000, 0, 900000000, 1800000000);
        send_pair(0, 0, 0, 900000000);
        send_pair(0, 0, 1, 1);
        send_pair(-1, -1, 0, 0);
        send_pair(300000000, 0, -300000000, 1800000000);
        send_pair(0, 0, 0, 1799999999);
        send_pair(-900000000, -1800000000, 900000000, 1800000000);
        send_pair(515000000, -1200000, 407000000, -740000000);

        for (int phase = 0; phase < 3; phase++) begin
            gap_percent = (phase == 0) ? 25 : (phase == 1) ? 67 : 0;
            for (int n = 0; n < 230; n++) begin
                case ($urandom_range(4))
                    0: begin
                        // Any bit pattern, out-of-range values included.
                        la = $urandom; lo = $urandom; lb = $urandom; lob = $urandom;
                    end
                    1: begin
                        // Near-antipodal pairs push the arc sine toward its limit.
                        la = rand_lat(); lo = rand_lon();
                        lb = -la + $urandom_range(2000) - 1000;
                        lob = (lo > 0 ? lo - 1800000000 : lo + 1800000000)
                              + $urandom_range(2000) - 1000;
                    end
                    2: begin
                        // Close neighbors.
                        la = rand_lat(); lo = rand_lon();
                        lb = la + $urandom_range(200) - 100;
                        lob = lo + $urandom_range(200) - 100;
                    end
                    default: begin
                        la = rand_lat(); lo = rand_lon(); lb = rand_lat(); lob = rand_lon();
                    end
                endcase
                send_pair(la, lo, lb, lob);
            end
        end
        i_start <= 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (130) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/gcd_pkg.sv
hw/rtl/gcd_cordic_cell.sv
hw/rtl/gcd_sqrt_cell.sv
hw/rtl/great_circle_distance_unit.sv
sim/gcd_distance_checker.sv
sim/tb_great_circle_distance_unit.sv
